// ----- hw/rtl/orcs_pkg.sv -----
// Package with the word types, record types and constants of the OPT cache set.
`default_nettype none
package orcs_pkg;

  localparam int unsigned TAG_W     = 31;
  localparam int unsigned TIME_W    = 31;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned OUT_WAY_W = 4;
  // Enough to number up to 1024 ways.
  localparam int unsigned WAY_IDX_W = 10;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef enum logic {
    CMD_ACCESS = 1'b0,
    CMD_FLUSH  = 1'b1
  } orcs_cmd_e;

  typedef struct packed {
    orcs_cmd_e          command;
    logic [TAG_W-1:0]   line_tag;
    logic [TIME_W-1:0]  next_use_time;
    logic               never_again;
  } orcs_in_t;

  typedef struct packed {
    logic                 hit;
    logic [OUT_WAY_W-1:0] way_used;
    logic                 evicted_valid;
    logic [TAG_W-1:0]     evicted_tag;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     access_total;
  } orcs_out_t;

  // Running search record handed from cell to cell.
  typedef struct packed {
    logic                 hit;
    logic [WAY_IDX_W-1:0] hit_way;
    logic                 found_never;
    logic                 have_best;
    logic [TIME_W-1:0]    best_nu;
    logic [WAY_IDX_W-1:0] vict_way;
    logic [TAG_W-1:0]     vict_tag;
  } orcs_rec_t;

  // Write broadcast from the control to all cells.
  typedef struct packed {
    logic                 clr;
    logic                 en;
    logic                 set_tag;
    logic [WAY_IDX_W-1:0] way;
    logic [TAG_W-1:0]     tag;
    logic [TIME_W-1:0]    nu;
    logic                 never;
  } orcs_wr_t;

endpackage
`default_nettype wire

// ----- hw/rtl/orcs_cell.sv -----
// One way of the set: stored line state plus one stage of the lookup and victim search.
`default_nettype none
module orcs_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      act_i,
  input  logic [orcs_pkg::TAG_W-1:0] query_tag_i,
  input  logic                      tok_i,
  input  orcs_pkg::orcs_rec_t       rec_i,
  input  orcs_pkg::orcs_wr_t        wr_i,
  output logic                      tok_o,
  output orcs_pkg::orcs_rec_t       rec_o
);
  import orcs_pkg::*;

  logic [TAG_W-1:0]  tag_q;
  logic [TIME_W-1:0] nu_q;
  logic              never_q;
  logic              valid_q;
  logic              tok_q;
  orcs_rec_t         rec_q, rec_d;
  logic              wr_sel;

  localparam logic [WAY_IDX_W-1:0] MyWay = WAY_IDX_W'(IDX);

  assign wr_sel = wr_i.en && (wr_i.way == MyWay);

  always_comb begin
    rec_d = rec_i;
    if (act_i) begin
      // The first matching way along the chain wins.
      if (valid_q && (tag_q == query_tag_i) && !rec_i.hit) begin
        rec_d.hit     = 1'b1;
        rec_d.hit_way = MyWay;
      end
      // A never-reused way overrides anything before it; otherwise keep the first maximum.
      if (never_q) begin
        rec_d.vict_way    = MyWay;
        rec_d.vict_tag    = tag_q;
        rec_d.found_never = 1'b1;
      end else if (!rec_i.found_never && (!rec_i.have_best || nu_q > rec_i.best_nu)) begin
        rec_d.vict_way  = MyWay;
        rec_d.vict_tag  = tag_q;
        rec_d.best_nu   = nu_q;
        rec_d.have_best = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      tok_q <= tok_i;
      if (wr_i.clr) begin
        valid_q <= 1'b0;
      end else if (wr_sel && wr_i.set_tag) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    if (!wr_i.clr && wr_sel) begin
      nu_q    <= wr_i.nu;
      never_q <= wr_i.never;
      if (wr_i.set_tag) begin
        tag_q <= wr_i.tag;
      end
    end
  end

  assign tok_o = tok_q;
  assign rec_o = rec_q;

endmodule
`default_nettype wire

// ----- hw/rtl/optimal_replacement_cache_set_top.sv -----
// Top level of the OPT cache set: request control, cell chain, write-back and counters.
//
//   channel | direction | handshake            | word
//   in      | input     | in_valid_i/in_stall_o | orcs_in_t: command, tag, next use, never
//   out     | output    | out_valid_o/out_stall_i | orcs_out_t: hit, way, eviction, totals
//   cfg     | input     | cfg_valid_i/cfg_ready_o | ways in use, 5 bits
//
// An access is taken into the request register, and then the request record walks the
// chain of cells one way per cycle and waits in the result register for its write-back.
// A flush takes effect and shows its result in the cycle after acceptance.
// Reset empties the set, clears the counters and sets ways in use to 16.
// A stalled output holds its word; a request is taken only when idle and the output is free.
`default_nettype none
module optimal_replacement_cache_set_top #(
  parameter int unsigned WAYS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  orcs_pkg::orcs_in_t    in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output orcs_pkg::orcs_out_t   out_word_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [orcs_pkg::CFG_W-1:0] cfg_data_i
);
  import orcs_pkg::*;

  localparam int unsigned FillW = $clog2(WAYS + 1);

  logic [CFG_W-1:0] ways_q;
  logic [CFG_W-1:0] ways_n;
  logic             busy_q, start_q, pend_q;
  orcs_in_t         req_q;
  orcs_rec_t        res_q;
  logic             out_valid_q;
  orcs_out_t        out_q, wb_out;
  logic [FillW-1:0] fill_q;
  logic [CNT_W-1:0] hit_cnt_q, acc_cnt_q, hit_cnt_d, acc_cnt_d;

  logic             in_acc, out_free, do_wb, is_flush, full;
  orcs_wr_t         wr;

  logic [WAYS-1:0]  act;
  logic [WAYS:0]    tok;
  orcs_rec_t        rec [WAYS+1];

  // Clamp the configured way count to 1..WAYS.
  always_comb begin
    if (ways_q == '0) begin
      ways_n = CFG_W'(1);
    end else if (32'(ways_q) > WAYS) begin
      ways_n = CFG_W'(WAYS);
    end else begin
      ways_n = ways_q;
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy_q || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_flush   = (in_word_i.command == CMD_FLUSH);
  assign do_wb      = pend_q && out_free;
  assign cfg_ready_o = !busy_q;

  assign full = !(32'(fill_q) < 32'(ways_n));

  assign hit_cnt_d = (res_q.hit && !(&hit_cnt_q)) ? hit_cnt_q + 1'b1 : hit_cnt_q;
  assign acc_cnt_d = (&acc_cnt_q) ? acc_cnt_q : acc_cnt_q + 1'b1;

  always_comb begin
    wr         = '0;
    wr.clr     = in_acc && is_flush;
    wr.en      = do_wb;
    wr.set_tag = !res_q.hit;
    wr.tag     = req_q.line_tag;
    wr.nu      = req_q.next_use_time;
    wr.never   = req_q.never_again;
    if (res_q.hit) begin
      wr.way = res_q.hit_way;
    end else if (!full) begin
      wr.way = WAY_IDX_W'(fill_q);
    end else begin
      wr.way = res_q.vict_way;
    end

    wb_out               = '0;
    wb_out.hit           = res_q.hit;
    wb_out.way_used      = wr.way[OUT_WAY_W-1:0];
    wb_out.evicted_valid = !res_q.hit && full;
    wb_out.evicted_tag   = (!res_q.hit && full) ? res_q.vict_tag : '0;
    wb_out.hit_total     = hit_cnt_d;
    wb_out.access_total  = acc_cnt_d;
  end

  assign rec[0] = '0;
  assign tok[0] = start_q;

  for (genvar i = 0; i < WAYS; i++) begin : g_cell
    assign act[i] = (32'(i) < 32'(ways_n));
    orcs_cell #(.IDX(i)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .act_i       (act[i]),
      .query_tag_i (req_q.line_tag),
      .tok_i       (tok[i]),
      .rec_i       (rec[i]),
      .wr_i        (wr),
      .tok_o       (tok[i+1]),
      .rec_o       (rec[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q      <= CFG_RESET;
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      fill_q      <= '0;
      hit_cnt_q   <= '0;
      acc_cnt_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        ways_q <= cfg_data_i;
      end
      start_q <= in_acc && !is_flush;
      if (in_acc && !is_flush) begin
        busy_q <= 1'b1;
      end else if (do_wb) begin
        busy_q <= 1'b0;
      end
      if (tok[WAYS]) begin
        pend_q <= 1'b1;
      end else if (do_wb) begin
        pend_q <= 1'b0;
      end
      if ((in_acc && is_flush) || do_wb) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc && is_flush) begin
        fill_q    <= '0;
        hit_cnt_q <= '0;
        acc_cnt_q <= '0;
      end else if (do_wb) begin
        hit_cnt_q <= hit_cnt_d;
        acc_cnt_q <= acc_cnt_d;
        if (!res_q.hit && !full) begin
          fill_q <= FillW'(fill_q + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_word_i;
    end
    if (tok[WAYS]) begin
      res_q <= rec[WAYS];
    end
    if (in_acc && is_flush) begin
      out_q <= '0;
    end else if (do_wb) begin
      out_q <= wb_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
`default_nettype wire

// ----- hw/rtl/orcs_checker.sv -----
// Port-level checker for the OPT cache set and its bind to the top level.
`default_nettype none
module orcs_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input orcs_pkg::orcs_in_t    in_word_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input orcs_pkg::orcs_out_t   out_word_o
);
  import orcs_pkg::*;

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A flush shows a valid result with zero totals in the next cycle.
  a_flush_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_word_i.command == CMD_FLUSH)
    |=> out_valid_o && (out_word_o.access_total == '0) && (out_word_o.hit_total == '0))
    else $error("flush result not zero");

  // An eviction only happens on a miss.
  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.evicted_valid |-> !out_word_o.hit)
    else $error("eviction reported on a hit");

  // A miss that fills or a hit carries no evicted tag.
  a_evict_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.evicted_valid |-> (out_word_o.evicted_tag == '0))
    else $error("evicted tag set without eviction");

  a_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.hit_total <= out_word_o.access_total))
    else $error("hit total exceeds access total");

endmodule

bind optimal_replacement_cache_set_top orcs_checker u_orcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
`default_nettype wire
